// File: rtl/core/mcfb_pkg.sv
// mcfb_pkg: beat types, frame constants and the crc-7 byte update
// shared by the frame builder top level and its test environment
// no dependencies
`default_nettype none

package mcfb_pkg;

  // command beat
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] speed;
  } cmd_t;

  // frame byte beat
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_t;

  // command kinds
  localparam logic [1:0] REQ_EXIT_SAFE = 2'd0;
  localparam logic [1:0] REQ_BRAKE     = 2'd1;
  localparam logic [1:0] REQ_SPEED     = 2'd2;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_INVERT      = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_SEND_CRC    = 2'd2;

  localparam int PADDR_W       = 4;
  localparam int SPEED_LIMIT_W = 15;

  // speed scaling
  localparam int FULL_SCALE   = 3200;
  localparam int FULL_SCALE_W = 12;
  localparam int MAG_W        = 15;
  localparam int PROD_W       = MAG_W + FULL_SCALE_W;
  localparam int FRAC_SHIFT   = 14;

  // frame bytes
  localparam logic [7:0] HDR_EXIT_SAFE = 8'h83;
  localparam logic [7:0] HDR_BRAKE     = 8'h92;
  localparam logic [7:0] BRAKE_DUTY    = 8'h20;
  localparam logic [7:0] HDR_FORWARD   = 8'h85;
  localparam logic [7:0] HDR_REVERSE   = 8'h86;
  localparam logic [7:0] CRC_POLY      = 8'h91;
  localparam logic [4:0] LOW_MASK      = 5'h1F;
  localparam logic [6:0] HIGH_MASK     = 7'h7F;

  // reflected crc-7, one byte, lsb first
  function automatic logic [7:0] crc7_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = c ^ CRC_POLY;
      end
      c = {1'b0, c[7:1]};
    end
    return c;
  endfunction

  // crc after fixed leading bytes
  localparam logic [7:0] CRC_EXIT_SAFE = crc7_byte(8'h00, HDR_EXIT_SAFE);
  localparam logic [7:0] CRC_BRAKE     = crc7_byte(crc7_byte(8'h00, HDR_BRAKE), BRAKE_DUTY);
  localparam logic [7:0] CRC_FORWARD   = crc7_byte(8'h00, HDR_FORWARD);
  localparam logic [7:0] CRC_REVERSE   = crc7_byte(8'h00, HDR_REVERSE);

endpackage

`default_nettype wire

// File: rtl/core/motor_command_frame_builder.sv
// motor_command_frame_builder: turns commands into serial motor controller
// frames (header, data bytes, optional crc-7), one byte per output beat
// depends on mcfb_pkg
//
//   port group   dir   beat / width        handshake
//   cmd          in    mcfb_pkg::cmd_t     cmd_valid / cmd_stall
//   frame        out   mcfb_pkg::frame_t   frame_valid / frame_stall
//   apb          in    4-bit paddr, 32b    psel / penable / pwrite, pready tied high
//
// five register stages: clamp, multiply, header + data bytes + crc through
// low byte, high byte crc + frame assembly, byte serializer. the serializer
// sends one byte a cycle while frame_stall is low and loads the next frame as
// the last byte leaves; a frame is 1 to 4 bytes (4 for set speed with crc).
// rst is synchronous: clears the valid bits and byte index, loads register defaults.
// stalls ripple back through the stage valid bits: a stage holds while the
// one after it is full and cannot move; nothing is dropped or sent twice.
`default_nettype none

module motor_command_frame_builder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command channel
  input  wire logic                              cmd_valid,
  output logic                                   cmd_stall,
  input  wire mcfb_pkg::cmd_t                    cmd,
  // frame byte channel
  output logic                                   frame_valid,
  input  wire logic                              frame_stall,
  output mcfb_pkg::frame_t                       frame,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mcfb_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import mcfb_pkg::*;

  // ---------------------------------------------------------------- registers
  logic                     invert_direction;
  logic [SPEED_LIMIT_W-1:0] speed_limit;
  logic                     send_crc;
  logic                     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_direction <= 1'b0;
      speed_limit      <= SPEED_LIMIT_W'(16384);
      send_crc         <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_INVERT:      invert_direction <= pwdata[0];
        REG_SPEED_LIMIT: speed_limit      <= pwdata[SPEED_LIMIT_W-1:0];
        REG_SEND_CRC:    send_crc         <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_INVERT:      prdata = {31'd0, invert_direction};
      REG_SPEED_LIMIT: prdata = {{(32-SPEED_LIMIT_W){1'b0}}, speed_limit};
      REG_SEND_CRC:    prdata = {31'd0, send_crc};
      default:         prdata = '0;
    endcase
  end

  // ------------------------------------------------------- stage flow control
  logic s1_valid, s2_valid, s3_valid, s4_valid, ser_valid;
  logic free1, free2, free3, free4, ser_free;
  logic frame_taken, ser_last;

  assign frame_taken = ser_valid && !frame_stall;
  // serializer can take a new frame when empty or its last byte leaves now
  assign ser_free    = !ser_valid || (frame_taken && ser_last);
  assign free4       = !s4_valid || ser_free;
  assign free3       = !s3_valid || free4;
  assign free2       = !s2_valid || free3;
  assign free1       = !s1_valid || free2;
  assign cmd_stall   = !free1;

  // ------------------------------------------- stage 1: invert and clamp speed
  logic signed [16:0]  v_sext, v_dir, v_lim, lim_pos, lim_neg;
  logic                v_neg;
  logic [MAG_W-1:0]    v_mag;
  logic [1:0]          s1_kind;
  logic                s1_neg;
  logic [MAG_W-1:0]    s1_mag;

  always_comb begin
    v_sext  = 17'(cmd.speed);
    v_dir   = invert_direction ? -v_sext : v_sext;
    lim_pos = signed'({2'b00, speed_limit});
    lim_neg = -lim_pos;
    if (v_dir > lim_pos) begin
      v_lim = lim_pos;
    end else if (v_dir < lim_neg) begin
      v_lim = lim_neg;
    end else begin
      v_lim = v_dir;
    end
    v_neg = v_lim[16];
    // magnitude fits 15 bits since the limit does
    v_mag = v_neg ? MAG_W'(-v_lim) : MAG_W'(v_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (free1) begin
      // unused command code makes no frame, so it never enters
      s1_valid <= cmd_valid && (cmd.req_type != REQ_UNUSED);
    end
  end

  always_ff @(posedge clk) begin
    if (free1 && cmd_valid) begin
      s1_kind <= cmd.req_type;
      s1_neg  <= v_neg;
      s1_mag  <= v_mag;
    end
  end

  // ---------------------------------------------- stage 2: scale to controller
  logic [PROD_W-1:0] prod;
  logic [1:0]        s2_kind;
  logic              s2_neg;
  logic [11:0]       s2_scaled;

  assign prod = PROD_W'(s1_mag) * PROD_W'(FULL_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (free2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free2 && s1_valid) begin
      s2_kind   <= s1_kind;
      s2_neg    <= s1_neg;
      // only the 12 bits carried by low and high bytes matter
      s2_scaled <= prod[FRAC_SHIFT+11:FRAC_SHIFT];
    end
  end

  // -------------------------- stage 3: header, data bytes, crc through byte 1
  logic [7:0] hdr_c, b1_c, b2_c, crc3_c;
  logic [1:0] nbytes_c;
  logic [1:0] s3_kind;
  logic [7:0] s3_hdr, s3_b1, s3_b2, s3_crc;
  logic [1:0] s3_nbytes;

  always_comb begin
    hdr_c    = HDR_EXIT_SAFE;
    b1_c     = 8'h00;
    b2_c     = 8'h00;
    crc3_c   = CRC_EXIT_SAFE;
    nbytes_c = 2'd1;
    case (s2_kind)
      REQ_BRAKE: begin
        hdr_c    = HDR_BRAKE;
        b1_c     = BRAKE_DUTY;
        crc3_c   = CRC_BRAKE;
        nbytes_c = 2'd2;
      end
      REQ_SPEED: begin
        hdr_c    = s2_neg ? HDR_REVERSE : HDR_FORWARD;
        b1_c     = {3'b000, s2_scaled[4:0] & LOW_MASK};
        b2_c     = {1'b0, s2_scaled[11:5] & HIGH_MASK};
        crc3_c   = crc7_byte(s2_neg ? CRC_REVERSE : CRC_FORWARD, b1_c);
        nbytes_c = 2'd3;
      end
      default: begin
        hdr_c    = HDR_EXIT_SAFE;
        crc3_c   = CRC_EXIT_SAFE;
        nbytes_c = 2'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (free3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free3 && s2_valid) begin
      s3_kind   <= s2_kind;
      s3_hdr    <= hdr_c;
      s3_b1     <= b1_c;
      s3_b2     <= b2_c;
      s3_crc    <= crc3_c;
      s3_nbytes <= nbytes_c;
    end
  end

  // ----------------------------- stage 4: finish crc, lay out the whole frame
  logic [7:0] crc4_c;
  logic [7:0] fb_c [4];
  logic [1:0] last_c;
  logic [7:0] s4_bytes [4];
  logic [1:0] s4_last;

  always_comb begin
    crc4_c = (s3_kind == REQ_SPEED) ? crc7_byte(s3_crc, s3_b2) : s3_crc;
    fb_c[0] = s3_hdr;
    fb_c[1] = s3_b1;
    fb_c[2] = s3_b2;
    fb_c[3] = 8'h00;
    if (send_crc) begin
      fb_c[s3_nbytes] = crc4_c;
      last_c = s3_nbytes;
    end else begin
      last_c = s3_nbytes - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (free4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free4 && s3_valid) begin
      s4_bytes <= fb_c;
      s4_last  <= last_c;
    end
  end

  // ------------------------------------------------ stage 5: byte serializer
  logic [7:0] ser_bytes [4];
  logic [1:0] ser_last_idx;
  logic [1:0] ser_idx;

  assign ser_last          = (ser_idx == ser_last_idx);
  assign frame_valid       = ser_valid;
  assign frame.frame_byte  = ser_bytes[ser_idx];
  assign frame.last_byte   = ser_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx   <= 2'd0;
    end else if (ser_free) begin
      ser_valid <= s4_valid;
      ser_idx   <= 2'd0;
    end else if (frame_taken) begin
      ser_idx   <= ser_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free && s4_valid) begin
      ser_bytes    <= s4_bytes;
      ser_last_idx <= s4_last;
    end
  end

endmodule

`default_nettype wire
